@@ hw/rtl/lbos_pkg.sv @@
// Package for the layered box overlap scanner: field widths, item structs and the box record.
// Depends on nothing; every other file of the block imports it.

package lbos_pkg;

    localparam int COORD_W = 16;
    localparam int SIZE_W  = 15;
    localparam int LAYER_W = 4;
    localparam int SLOT_W  = 3;

    // Doubled centre plus or minus a size, and the span between two such ends.
    localparam int EXT_W  = COORD_W + 2;
    localparam int DIFF_W = EXT_W + 1;
    localparam int SUM_W  = SIZE_W + 1;

    typedef enum logic {
        FUNC_WRITE = 1'b0,
        FUNC_SCAN  = 1'b1
    } t_func;

    typedef struct packed {
        t_func                      func;
        logic [SLOT_W-1:0]          slot;
        logic                       enable;
        logic [LAYER_W-1:0]         src_layer;
        logic [LAYER_W-1:0]         dst_layer;
        logic                       has_handler;
        logic signed [COORD_W-1:0]  center_x;
        logic signed [COORD_W-1:0]  center_y;
        logic [SIZE_W-1:0]          width;
        logic [SIZE_W-1:0]          height;
    } t_in_item;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] src_slot;
        logic [SLOT_W-1:0] dst_slot;
        logic              last;
    } t_out_item;

    typedef struct packed {
        logic [LAYER_W-1:0]         src_layer;
        logic [LAYER_W-1:0]         dst_layer;
        logic                       handler;
        logic signed [COORD_W-1:0]  center_x;
        logic signed [COORD_W-1:0]  center_y;
        logic [SIZE_W-1:0]          width;
        logic [SIZE_W-1:0]          height;
    } t_box;

    // Command passed from the front end to the scan engine.
    typedef struct packed {
        logic              is_scan;
        logic [SLOT_W-1:0] slot;
        logic              enable;
        t_box              box;
    } t_cmd;

endpackage

@@ hw/rtl/lbos_front.sv @@
// Front end of the box scanner: accepts input transfers, classifies them and queues commands.
// Depends on lbos_pkg.

module lbos_front import lbos_pkg::*; #(
    parameter int MAX_BOXES = 8
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_in_item i_in_data,
    output logic     o_in_stall,
    output logic     o_cmd_valid,
    output t_cmd     o_cmd,
    input  logic     i_cmd_pop
);

    localparam int DEPTH = 2;
    localparam int PTR_W = 1;
    localparam int CNT_W = 2;

    t_cmd             r_q [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    logic accept;
    logic slot_ok;
    logic push;
    logic pop;
    t_cmd cmd;

    assign o_in_stall  = (r_count == CNT_W'(DEPTH));
    assign accept      = i_in_valid && !o_in_stall;
    assign slot_ok     = (int'(i_in_data.slot) < MAX_BOXES);
    // A write to a slot beyond the table is dropped here and never reaches the engine.
    assign push        = accept && ((i_in_data.func == FUNC_SCAN) || slot_ok);
    assign pop         = i_cmd_pop && (r_count != '0);
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q[r_rd_ptr];

    always_comb begin
        cmd               = '0;
        cmd.is_scan       = (i_in_data.func == FUNC_SCAN);
        cmd.slot          = i_in_data.slot;
        cmd.enable        = i_in_data.enable;
        cmd.box.src_layer = i_in_data.src_layer;
        cmd.box.dst_layer = i_in_data.dst_layer;
        cmd.box.handler   = i_in_data.has_handler;
        cmd.box.center_x  = i_in_data.center_x;
        cmd.box.center_y  = i_in_data.center_y;
        cmd.box.width     = i_in_data.width;
        cmd.box.height    = i_in_data.height;
    end

    always_comb begin
        n_count = r_count;
        if (push && !pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (pop && !push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cmd;
        end
    end

endmodule

@@ hw/rtl/lbos_back.sv @@
// Scan engine of the box scanner: box table, pair sequencer, overlap pipeline and output register.
// Depends on lbos_pkg.

module lbos_back import lbos_pkg::*; #(
    parameter int MAX_BOXES = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_cmd_pop,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  logic      i_out_stall
);

    localparam int IDX_W = $clog2(MAX_BOXES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_BOXES - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } t_state;

    t_state r_state;

    t_box                 r_mem [MAX_BOXES];
    logic [MAX_BOXES-1:0] r_en;

    logic [IDX_W-1:0] r_s;
    logic [IDX_W-1:0] r_d;
    logic             r_any;
    logic             r_out_valid;
    t_out_item        r_out;

    // Stage 1: table entries of both boxes.
    logic             r_p1_valid;
    logic [IDX_W-1:0] r_p1_s;
    logic [IDX_W-1:0] r_p1_d;
    t_box             r_p1_bs;
    t_box             r_p1_bd;
    logic             r_p1_en;

    // Stage 2: union ends and size sums per axis.
    logic                     r_p2_valid;
    logic [IDX_W-1:0]         r_p2_s;
    logic [IDX_W-1:0]         r_p2_d;
    logic                     r_p2_ok;
    logic signed [EXT_W-1:0]  r_p2_xhi;
    logic signed [EXT_W-1:0]  r_p2_xlo;
    logic [SUM_W-1:0]         r_p2_xsum;
    logic signed [EXT_W-1:0]  r_p2_yhi;
    logic signed [EXT_W-1:0]  r_p2_ylo;
    logic [SUM_W-1:0]         r_p2_ysum;

    // Stage 3: pair verdict.
    logic             r_p3_valid;
    logic [IDX_W-1:0] r_p3_s;
    logic [IDX_W-1:0] r_p3_d;
    logic             r_p3_hit;

    logic advance;
    logic issue;
    logic drain_done;
    logic scan_start;
    logic write_now;

    logic signed [EXT_W-1:0]  xhi_s, xhi_d, xlo_s, xlo_d;
    logic signed [EXT_W-1:0]  yhi_s, yhi_d, ylo_s, ylo_d;
    logic                     pair_ok;
    logic signed [DIFF_W-1:0] xdiff, ydiff, xlim, ylim;
    logic                     pair_hit;

    function automatic logic signed [EXT_W-1:0] dbl(input logic signed [COORD_W-1:0] c);
        dbl = {c[COORD_W-1], c, 1'b0};
    endfunction

    function automatic logic signed [EXT_W-1:0] zext(input logic [SIZE_W-1:0] w);
        zext = {{(EXT_W-SIZE_W){1'b0}}, w};
    endfunction

    // The whole pipeline moves only when the output register can take a result.
    assign advance    = !r_out_valid || !i_out_stall;
    assign issue      = (r_state == ST_SCAN) && advance;
    assign o_cmd_pop  = (r_state == ST_IDLE) && i_cmd_valid;
    assign scan_start = o_cmd_pop && i_cmd.is_scan;
    assign write_now  = o_cmd_pop && !i_cmd.is_scan;
    assign drain_done = (r_state == ST_DRAIN) && advance
                        && !r_p1_valid && !r_p2_valid && !r_p3_valid;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        xhi_s = dbl(r_p1_bs.center_x) + zext(r_p1_bs.width);
        xlo_s = dbl(r_p1_bs.center_x) - zext(r_p1_bs.width);
        xhi_d = dbl(r_p1_bd.center_x) + zext(r_p1_bd.width);
        xlo_d = dbl(r_p1_bd.center_x) - zext(r_p1_bd.width);
        yhi_s = dbl(r_p1_bs.center_y) + zext(r_p1_bs.height);
        ylo_s = dbl(r_p1_bs.center_y) - zext(r_p1_bs.height);
        yhi_d = dbl(r_p1_bd.center_y) + zext(r_p1_bd.height);
        ylo_d = dbl(r_p1_bd.center_y) - zext(r_p1_bd.height);
        pair_ok = r_p1_en && (r_p1_bs.dst_layer != '0)
                  && (r_p1_bd.src_layer == r_p1_bs.dst_layer) && r_p1_bd.handler;
    end

    always_comb begin
        xdiff = DIFF_W'(r_p2_xhi) - DIFF_W'(r_p2_xlo);
        ydiff = DIFF_W'(r_p2_yhi) - DIFF_W'(r_p2_ylo);
        xlim  = $signed({{(DIFF_W-SUM_W-1){1'b0}}, r_p2_xsum, 1'b0});
        ylim  = $signed({{(DIFF_W-SUM_W-1){1'b0}}, r_p2_ysum, 1'b0});
        pair_hit = r_p2_ok && (xdiff <= xlim) && (ydiff <= ylim);
    end

    // Box table; enable bits are cleared by reset, the rest is defined by its first write.
    always_ff @(posedge i_clk) begin
        if (write_now) begin
            r_mem[i_cmd.slot[IDX_W-1:0]] <= i_cmd.box;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en <= '0;
        end else if (write_now) begin
            r_en[i_cmd.slot[IDX_W-1:0]] <= i_cmd.enable;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
            r_p3_valid <= 1'b0;
        end else if (advance) begin
            r_p1_valid <= issue;
            r_p2_valid <= r_p1_valid;
            r_p3_valid <= r_p2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_p1_s    <= r_s;
            r_p1_d    <= r_d;
            r_p1_bs   <= r_mem[r_s];
            r_p1_bd   <= r_mem[r_d];
            r_p1_en   <= r_en[r_s] && r_en[r_d] && (r_s != r_d);

            r_p2_s    <= r_p1_s;
            r_p2_d    <= r_p1_d;
            r_p2_ok   <= pair_ok;
            r_p2_xhi  <= (xhi_s > xhi_d) ? xhi_s : xhi_d;
            r_p2_xlo  <= (xlo_s < xlo_d) ? xlo_s : xlo_d;
            r_p2_xsum <= SUM_W'(r_p1_bs.width) + SUM_W'(r_p1_bd.width);
            r_p2_yhi  <= (yhi_s > yhi_d) ? yhi_s : yhi_d;
            r_p2_ylo  <= (ylo_s < ylo_d) ? ylo_s : ylo_d;
            r_p2_ysum <= SUM_W'(r_p1_bs.height) + SUM_W'(r_p1_bd.height);

            r_p3_s    <= r_p2_s;
            r_p3_d    <= r_p2_d;
            r_p3_hit  <= pair_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_s         <= '0;
            r_d         <= '0;
            r_any       <= 1'b0;
            r_out_valid <= 1'b0;
            r_out       <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (scan_start) begin
                        r_state <= ST_SCAN;
                        r_s     <= '0;
                        r_d     <= '0;
                        r_any   <= 1'b0;
                    end
                end
                ST_SCAN: begin
                    if (issue) begin
                        if (r_d == LAST_IDX) begin
                            r_d <= '0;
                            if (r_s == LAST_IDX) begin
                                r_state <= ST_DRAIN;
                            end else begin
                                r_s <= r_s + IDX_W'(1);
                            end
                        end else begin
                            r_d <= r_d + IDX_W'(1);
                        end
                    end
                end
                ST_DRAIN: begin
                    if (drain_done) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase

            if (advance) begin
                if (r_p3_valid && r_p3_hit) begin
                    r_out_valid    <= 1'b1;
                    r_out.hit      <= 1'b1;
                    r_out.src_slot <= SLOT_W'(r_p3_s);
                    r_out.dst_slot <= SLOT_W'(r_p3_d);
                    r_out.last     <= 1'b0;
                    r_any          <= 1'b1;
                end else if (drain_done) begin
                    r_out_valid    <= 1'b1;
                    r_out.hit      <= r_any;
                    r_out.src_slot <= '0;
                    r_out.dst_slot <= '0;
                    r_out.last     <= 1'b1;
                end else begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

endmodule

@@ hw/rtl/layered_box_overlap_scanner.sv @@
// Top level of the layered box overlap scanner: front end, command queue and scan engine.
// Depends on lbos_pkg, lbos_front and lbos_back.
//
//   Channel   Direction  Handshake                  Payload
//   input     in         i_in_valid / o_in_stall    i_in_data  (t_in_item)
//   result    out        o_out_valid / i_out_stall  o_out_data (t_out_item)
//
// A write item is written into the box table as the engine pops it. A scan visits every
// ordered slot pair, one pair per cycle while the result side is not stalled, through
// the pair sequencer and the three-stage overlap pipeline.
// A two-entry command queue lets new items be taken while a scan runs.
// Reset clears every box's enable bit; no clearing pass is needed.
// A stalled result freezes the whole overlap pipeline until the transfer completes.

module layered_box_overlap_scanner import lbos_pkg::*; #(
    parameter int MAX_BOXES = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_data,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  logic      i_out_stall
);

    logic cmd_valid;
    logic cmd_pop;
    t_cmd cmd;

    lbos_front #(
        .MAX_BOXES (MAX_BOXES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    lbos_back #(
        .MAX_BOXES (MAX_BOXES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

@@ tb/overlap_hit_checker.sv @@
`timescale 1ns / 100ps
// Result checker for the layered box overlap scanner: mirrors the box table, predicts the
// hits of every accepted scan and compares them with each result transfer. Depends on lbos_pkg.

module overlap_hit_checker import lbos_pkg::*; #(
    parameter int BOX_SLOTS = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_item i_out_data,
    output int        o_fail_count,
    output int        o_pending
);

    logic      box_live [BOX_SLOTS];
    t_box      box_tab  [BOX_SLOTS];
    t_out_item expected_hits [$];
    int        mismatches;

    // Inclusive overlap on one axis, worked on doubled coordinates at full precision.
    function automatic bit spans_meet(longint c_a, longint s_a, longint c_b, longint s_b);
        longint top_a, top_b, bot_a, bot_b, hi, lo;
        top_a = 2 * c_a + s_a;
        top_b = 2 * c_b + s_b;
        bot_a = 2 * c_a - s_a;
        bot_b = 2 * c_b - s_b;
        hi = (top_a > top_b) ? top_a : top_b;
        lo = (bot_a < bot_b) ? bot_a : bot_b;
        return (hi - lo) <= 2 * (s_a + s_b);
    endfunction

    function automatic bit boxes_meet(t_box a, t_box b);
        return spans_meet($signed(a.center_x), a.width, $signed(b.center_x), b.width)
            && spans_meet($signed(a.center_y), a.height, $signed(b.center_y), b.height);
    endfunction

    task automatic predict_hits();
        t_out_item r;
        int        found;
        found = 0;
        for (int s = 0; s < BOX_SLOTS; s++) begin
            if (!box_live[s] || box_tab[s].dst_layer == '0) continue;
            for (int d = 0; d < BOX_SLOTS; d++) begin
                if (d == s || !box_live[d]) continue;
                if (box_tab[d].src_layer != box_tab[s].dst_layer) continue;
                if (!boxes_meet(box_tab[s], box_tab[d]) || !box_tab[d].handler) continue;
                r = '0;
                r.hit = 1'b1;
                r.src_slot = SLOT_W'(s);
                r.dst_slot = SLOT_W'(d);
                expected_hits.insert(expected_hits.size(), r);
                found++;
            end
        end
        // Every scan closes with one marker; hit tells whether anything was reported.
        r = '0;
        r.hit = (found > 0);
        r.last = 1'b1;
        expected_hits.insert(expected_hits.size(), r);
    endtask

    task automatic report_field(string field, logic [7:0] want, logic [7:0] got);
        $display("%0t: result field %s mismatch, expected %0d, actual %0d",
                 $time, field, want, got);
        mismatches++;
    endtask

    always @(posedge i_clk) begin : watch
        t_out_item want;
        int        idx;
        if (!i_rst_n) begin
            for (int i = 0; i < BOX_SLOTS; i++) begin
                box_live[i] = 1'b0;
            end
            expected_hits.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                if (i_in_data.func == FUNC_SCAN) begin
                    predict_hits();
                end else if (int'(i_in_data.slot) < BOX_SLOTS) begin
                    idx = int'(i_in_data.slot);
                    box_live[idx]          = i_in_data.enable;
                    box_tab[idx].src_layer = i_in_data.src_layer;
                    box_tab[idx].dst_layer = i_in_data.dst_layer;
                    box_tab[idx].handler   = i_in_data.has_handler;
                    box_tab[idx].center_x  = i_in_data.center_x;
                    box_tab[idx].center_y  = i_in_data.center_y;
                    box_tab[idx].width     = i_in_data.width;
                    box_tab[idx].height    = i_in_data.height;
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_hits.size() == 0) begin
                    $display("%0t: result transfer mismatch, expected none, actual %p",
                             $time, i_out_data);
                    mismatches++;
                end else begin
                    want = expected_hits.pop_front();
                    if (i_out_data.hit !== want.hit)
                        report_field("hit", 8'(want.hit), 8'(i_out_data.hit));
                    if (i_out_data.src_slot !== want.src_slot)
                        report_field("src_slot", 8'(want.src_slot), 8'(i_out_data.src_slot));
                    if (i_out_data.dst_slot !== want.dst_slot)
                        report_field("dst_slot", 8'(want.dst_slot), 8'(i_out_data.dst_slot));
                    if (i_out_data.last !== want.last)
                        report_field("last", 8'(want.last), 8'(i_out_data.last));
                end
            end
        end
        o_pending    <= expected_hits.size();
        o_fail_count <= mismatches;
    end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// Top of the overlap scanner testbench: clock, reset, item and stall stimulus, watchdog
// and verdict. Depends on lbos_pkg, layered_box_overlap_scanner and overlap_hit_checker.

module testbench;
    import lbos_pkg::*;

    localparam int MAX_BOXES   = 8;
    localparam int PHASE_ITEMS = 100;
    localparam int LONG_HOLD   = 300;
    localparam int QUIET_LIMIT = 4000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_item  in_data;
    logic      out_valid;
    logic      out_stall;
    t_out_item out_data;

    int fail_count;
    int pending;
    int quiet_cycles;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_token;
    int hold_served;

    always begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    layered_box_overlap_scanner #(
        .MAX_BOXES(MAX_BOXES)
    ) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall)
    );

    overlap_hit_checker #(
        .BOX_SLOTS(MAX_BOXES)
    ) i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Watchdog: counts cycles without a transfer on either channel.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Result side: random stalls, plus a long hold-off whenever the stimulus asks for one.
    initial begin
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_token != hold_served) begin
                hold_served = hold_token;
                repeat (LONG_HOLD) begin
                    out_stall <= 1'b1;
                    @(posedge clk);
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    function automatic t_in_item random_bits();
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        return raw[$bits(t_in_item)-1:0];
    endfunction

    // A scan ignores everything but func, so the other fields carry noise.
    function automatic t_in_item scan_item();
        t_in_item it;
        it = random_bits();
        it.func = FUNC_SCAN;
        return it;
    endfunction

    function automatic t_in_item box_write(int slot, bit en, int src, int dst, bit hnd,
                                           int cx, int cy, int w, int h);
        t_in_item it;
        it = '0;
        it.func        = FUNC_WRITE;
        it.slot        = SLOT_W'(slot);
        it.enable      = en;
        it.src_layer   = LAYER_W'(src);
        it.dst_layer   = LAYER_W'(dst);
        it.has_handler = hnd;
        it.center_x    = COORD_W'(cx);
        it.center_y    = COORD_W'(cy);
        it.width       = SIZE_W'(w);
        it.height      = SIZE_W'(h);
        return it;
    endfunction

    // Most writes place boxes on a few layers close together so that scans find pairs;
    // the rest carry fully random fields.
    function automatic t_in_item random_item();
        t_in_item it;
        if ($urandom_range(99) < 25) return scan_item();
        it = random_bits();
        it.func = FUNC_WRITE;
        if ($urandom_range(99) < 70) begin
            it.enable      = ($urandom_range(99) < 85);
            it.src_layer   = LAYER_W'($urandom_range(3, 1));
            it.dst_layer   = LAYER_W'($urandom_range(3, 0));
            it.has_handler = ($urandom_range(99) < 75);
            it.center_x    = COORD_W'(int'($urandom_range(400)) - 200);
            it.center_y    = COORD_W'(int'($urandom_range(400)) - 200);
            it.width       = SIZE_W'($urandom_range(320));
            it.height      = SIZE_W'($urandom_range(320));
        end
        return it;
    endfunction

    task automatic send_item(input t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic run_phase(input int count);
        for (int k = 0; k < count; k++) begin
            send_item(random_item());
        end
    endtask

    initial begin
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        in_data       <= '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: empty table, touching edges, a zero-size box on a corner,
        // a box whose own layer is its target, a target without a handler, a near miss,
        // then extreme coordinates and sizes, and removal of a box.
        send_item(scan_item());
        send_item(box_write(0, 1, 1, 2, 1, 0, 0, 16, 16));
        send_item(box_write(1, 1, 2, 0, 1, 16, 0, 16, 16));
        send_item(box_write(2, 1, 2, 0, 1, 8, 8, 0, 0));
        send_item(box_write(3, 1, 3, 3, 1, 0, 0, 32, 32));
        send_item(box_write(4, 1, 2, 0, 0, 0, 0, 8, 8));
        send_item(box_write(5, 1, 2, 0, 1, 17, 0, 16, 16));
        send_item(scan_item());
        send_item(box_write(6, 1, 4, 5, 1, -32768, 32767, 32767, 32767));
        send_item(box_write(7, 1, 5, 4, 1, -1, 0, 32767, 32767));
        send_item(scan_item());
        send_item(box_write(0, 0, 15, 15, 1, 32767, -32768, 32767, 32767));
        send_item(box_write(5, 1, 15, 15, 0, -1, -1, 0, 0));
        send_item(box_write(1, 1, 2, 15, 1, 0, 0, 0, 0));
        send_item(scan_item());
        wait_drained();

        send_idle_pct = 17;
        recv_idle_pct = 66;
        run_phase(PHASE_ITEMS);
        wait_drained();

        send_idle_pct = 66;
        recv_idle_pct = 17;
        run_phase(PHASE_ITEMS);
        wait_drained();

        // Hold the result side off while scans keep coming, so the input backs up.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_token <= hold_token + 1;
        for (int k = 0; k < 12; k++) begin
            send_item((k % 2 == 1) ? scan_item() : random_item());
        end
        run_phase(PHASE_ITEMS);
        wait_drained();
        repeat (80) @(posedge clk);

        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/lbos_pkg.sv
hw/rtl/lbos_front.sv
hw/rtl/lbos_back.sv
hw/rtl/layered_box_overlap_scanner.sv
tb/overlap_hit_checker.sv
tb/testbench.sv
